/* hw/rtl/jseu_pkg.sv */
// Shared types, constants and helpers for the JSON string escaper.
`default_nettype none

package jseu_pkg;

  // Depth of the command queue between front and back
  localparam int unsigned JSEU_FIFO_DEPTH = 2;

  // Characters that both halves emit
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  // Payload of one input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_string;
  } in_item_t;

  // Payload of one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  // How the middle segment of an item is rendered
  typedef enum logic [2:0] {
    MAIN_NONE,
    MAIN_RAW,
    MAIN_SHORT,
    MAIN_UNI,
    MAIN_FFFD
  } main_e;

  // Output plan of one item, emitted in field order:
  // opening quote, failed-sequence escapes, passed UTF-8 bytes,
  // main segment, truncation escapes, closing quote.
  typedef struct packed {
    logic            open_quote;
    logic [1:0]      fail_n;
    logic [2:0]      pass_n;
    logic [3:0][7:0] pass_bytes;
    main_e           main_kind;
    logic [7:0]      main_byte;
    logic [1:0]      flush_n;
    logic            close_quote;
  } cmd_t;

  // True when a plan has nothing left to emit
  function automatic logic cmd_empty(input cmd_t c);
    cmd_empty = !c.open_quote && (c.fail_n == 2'd0) && (c.pass_n == 3'd0) &&
                (c.main_kind == MAIN_NONE) && (c.flush_n == 2'd0) && !c.close_quote;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/json_string_escaper_utf8_check.sv */
// JSON string escaper with UTF-8 checking: with the emitter idle, an accepted item is
// written to the command queue, loaded as the emitter's plan, then sent to the output register.
// The queue takes one item per cycle while not full; the emitter sends one byte per cycle
// while the output is not stalled, and one item can expand to up to 25 bytes.
// The input stalls only while the command queue is full.
// Reset clears the pending UTF-8 sequence, the queue and the output register.
`default_nettype none

module json_string_escaper_utf8_check
  import jseu_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = JSEU_FIFO_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  cmd_t front_cmd, queue_cmd;
  logic push, full, pop, queue_valid, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jseu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cmd_o    (front_cmd),
    .push_o   (push)
  );

  jseu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_cmd),
    .valid_o (queue_valid)
  );

  jseu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/jseu_front.sv */
// Front end: tracks pending UTF-8 sequences and turns each item into an output plan.
`default_nettype none

module jseu_front
  import jseu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire in_item_t item_i,
  output cmd_t          cmd_o,
  output logic          push_o
);

  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD_ED  = 8'hed;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hbf;
  localparam logic [7:0] E0_LO    = 8'ha0;
  localparam logic [7:0] ED_HI    = 8'h9f;
  localparam logic [7:0] F0_LO    = 8'h90;
  localparam logic [7:0] F4_HI    = 8'h8f;
  localparam logic [7:0] CTRL_END = 8'h20;

  logic [7:0]      lead_q, lead_d;
  logic [1:0][7:0] cont_q, cont_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      len_q, len_d;

  logic [7:0] b;
  logic       pend;
  logic       fresh_go;
  logic       ok;
  logic [7:0] lo, hi;
  logic [2:0] lead_len;
  cmd_t       cmd;

  assign b = item_i.in_byte;

  // Allowed range for the next continuation byte
  always_comb begin
    lo = CONT_LO;
    hi = CONT_HI;
    if (cnt_q == 2'd0) begin
      if (lead_q == LEAD3_LO) begin
        lo = E0_LO;
      end else if (lead_q == LEAD_ED) begin
        hi = ED_HI;
      end else if (lead_q == LEAD4_LO) begin
        lo = F0_LO;
      end else if (lead_q == LEAD4_HI) begin
        hi = F4_HI;
      end
    end
    ok = (b >= lo) && (b <= hi);
  end

  // Expected sequence length when the byte starts a sequence
  always_comb begin
    if (b >= LEAD2_LO && b <= LEAD2_HI) begin
      lead_len = 3'd2;
    end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
      lead_len = 3'd3;
    end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  // Plan and next UTF-8 state for the item on the port
  always_comb begin
    cmd      = '0;
    lead_d   = lead_q;
    cont_d   = cont_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    fresh_go = 1'b0;
    pend     = (len_q != 3'd0) && !item_i.first_byte;
    if (item_i.empty_string) begin
      cmd.open_quote  = 1'b1;
      cmd.close_quote = 1'b1;
      cnt_d = 2'd0;
      len_d = 3'd0;
    end else begin
      cmd.open_quote = item_i.first_byte;
      if (item_i.first_byte) begin
        cnt_d = 2'd0;
        len_d = 3'd0;
      end
      if (!pend) begin
        fresh_go = 1'b1;
      end else if (ok) begin
        if ({1'b0, cnt_q} + 3'd2 >= len_q) begin
          // sequence complete: release it unchanged
          cmd.pass_n        = {1'b0, cnt_q} + 3'd2;
          cmd.pass_bytes[0] = lead_q;
          case (cnt_q)
            2'd0: begin
              cmd.pass_bytes[1] = b;
            end
            2'd1: begin
              cmd.pass_bytes[1] = cont_q[0];
              cmd.pass_bytes[2] = b;
            end
            default: begin
              cmd.pass_bytes[1] = cont_q[0];
              cmd.pass_bytes[2] = cont_q[1];
              cmd.pass_bytes[3] = b;
            end
          endcase
          cnt_d = 2'd0;
          len_d = 3'd0;
        end else begin
          cont_d[cnt_q[0]] = b;
          cnt_d = cnt_q + 2'd1;
        end
      end else begin
        // malformed: lead and held bytes each become a replacement escape
        cmd.fail_n = cnt_q + 2'd1;
        cnt_d      = 2'd0;
        len_d      = 3'd0;
        fresh_go   = 1'b1;
      end

      if (fresh_go) begin
        cmd.main_byte = b;
        if (lead_len != 3'd0) begin
          lead_d = b;
          cnt_d  = 2'd0;
          len_d  = lead_len;
        end else if (b >= CONT_LO) begin
          cmd.main_kind = MAIN_FFFD;
        end else begin
          cmd.main_kind = MAIN_SHORT;
          case (b)
            CH_QUOTE:  cmd.main_byte = CH_QUOTE;
            CH_BSLASH: cmd.main_byte = CH_BSLASH;
            8'h08:     cmd.main_byte = 8'h62;
            8'h0c:     cmd.main_byte = 8'h66;
            8'h0a:     cmd.main_byte = 8'h6e;
            8'h0d:     cmd.main_byte = 8'h72;
            8'h09:     cmd.main_byte = 8'h74;
            default: begin
              cmd.main_kind = (b < CTRL_END) ? MAIN_UNI : MAIN_RAW;
            end
          endcase
        end
      end

      // truncated sequence at end of string
      if (item_i.last_byte) begin
        if (len_d != 3'd0) begin
          cmd.flush_n = cnt_d + 2'd1;
          cnt_d = 2'd0;
          len_d = 3'd0;
        end
        cmd.close_quote = 1'b1;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && !cmd_empty(cmd);

  // UTF-8 pending state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      cnt_q  <= '0;
      len_q  <= '0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
    end
  end

  // Held continuation bytes
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cont_q <= cont_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jseu_fifo.sv */
// Command queue between the front end and the byte emitter.
`default_nettype none

module jseu_fifo
  import jseu_pkg::*;
#(
  parameter int unsigned DEPTH = JSEU_FIFO_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jseu_back.sv */
// Byte emitter: walks one output plan at a time and drives the output register.
`default_nettype none

module jseu_back
  import jseu_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [7:0] CH_U    = 8'h75;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [2:0] SUB_END = 3'd5;

  cmd_t       w_q, w_d;
  logic       busy_q;
  logic [2:0] sub_q, sub_d;
  logic       out_valid_q;
  out_item_t  out_q;

  logic [7:0] byte_c;
  logic       done_c;
  logic       last_c;
  logic       emit;
  logic       take;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    hex_char = (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction

  function automatic logic [7:0] fffd_char(input logic [2:0] idx);
    case (idx)
      3'd0:    fffd_char = CH_BSLASH;
      3'd1:    fffd_char = CH_U;
      3'd5:    fffd_char = CH_D;
      default: fffd_char = CH_F;
    endcase
  endfunction

  // Next byte of the current plan and what remains afterwards
  always_comb begin
    w_d    = w_q;
    sub_d  = sub_q;
    byte_c = CH_QUOTE;
    done_c = 1'b0;
    if (w_q.open_quote) begin
      w_d.open_quote = 1'b0;
    end else if (w_q.fail_n != 2'd0) begin
      byte_c = fffd_char(sub_q);
      if (sub_q == SUB_END) begin
        sub_d      = 3'd0;
        w_d.fail_n = w_q.fail_n - 2'd1;
      end else begin
        sub_d = sub_q + 3'd1;
      end
    end else if (w_q.pass_n != 3'd0) begin
      byte_c         = w_q.pass_bytes[0];
      w_d.pass_bytes = w_q.pass_bytes >> 8;
      w_d.pass_n     = w_q.pass_n - 3'd1;
    end else if (w_q.main_kind != MAIN_NONE) begin
      sub_d = sub_q + 3'd1;
      case (w_q.main_kind)
        MAIN_RAW: begin
          byte_c        = w_q.main_byte;
          sub_d         = 3'd0;
          w_d.main_kind = MAIN_NONE;
        end
        MAIN_SHORT: begin
          byte_c = (sub_q == 3'd0) ? CH_BSLASH : w_q.main_byte;
          if (sub_q != 3'd0) begin
            sub_d         = 3'd0;
            w_d.main_kind = MAIN_NONE;
          end
        end
        MAIN_UNI: begin
          case (sub_q)
            3'd0:    byte_c = CH_BSLASH;
            3'd1:    byte_c = CH_U;
            3'd4:    byte_c = hex_char(w_q.main_byte[7:4]);
            3'd5:    byte_c = hex_char(w_q.main_byte[3:0]);
            default: byte_c = CH_ZERO;
          endcase
          if (sub_q == SUB_END) begin
            sub_d         = 3'd0;
            w_d.main_kind = MAIN_NONE;
          end
        end
        default: begin
          byte_c = fffd_char(sub_q);
          if (sub_q == SUB_END) begin
            sub_d         = 3'd0;
            w_d.main_kind = MAIN_NONE;
          end
        end
      endcase
    end else if (w_q.flush_n != 2'd0) begin
      byte_c = fffd_char(sub_q);
      if (sub_q == SUB_END) begin
        sub_d       = 3'd0;
        w_d.flush_n = w_q.flush_n - 2'd1;
      end else begin
        sub_d = sub_q + 3'd1;
      end
    end else begin
      done_c          = 1'b1;
      w_d.close_quote = 1'b0;
    end
    last_c = cmd_empty(w_d);
  end

  assign emit  = busy_q && (!out_valid_q || !out_stall_i);
  assign take  = cmd_valid_i && (!busy_q || (emit && last_c));
  assign pop_o = take;

  // Current plan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sub_q  <= '0;
    end else if (take) begin
      busy_q <= 1'b1;
      sub_q  <= '0;
    end else if (emit) begin
      busy_q <= !last_c;
      sub_q  <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      w_q <= cmd_i;
    end else if (emit) begin
      w_q <= w_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= byte_c;
      out_q.run_last    <= last_c;
      out_q.string_done <= done_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire
